@@ src/mqf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mqf_pkg
// Shared types and constants of the multi-queue fifo engine: operation
// codes, status codes, controller states and default parameter values.
// ---------------------------------------------------------------------------
package mqf_pkg;

   // fixed field widths of the request and response
   localparam int KIND_W      = 2;
   localparam int QSEL_W      = 3;
   localparam int PUSH_W      = 32;
   localparam int POP_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int FILL_OUT_W  = 9;

   // parameter defaults
   localparam int MQF_QUEUE_COUNT = 8;
   localparam int MQF_QUEUE_DEPTH = 256;
   localparam int MQF_DATA_WIDTH  = 32;

   typedef enum logic [KIND_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_FINISH
   } state_type;

   // control decisions of one descriptor update
   typedef struct packed {
      logic       desc_we;
      logic       elem_we;
      logic       elem_re;
      status_type status;
   } upd_ctrl_type;

endpackage : mqf_pkg
`default_nettype wire

@@ src/mqf_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mqf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset on the contents.
// ---------------------------------------------------------------------------
module mqf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : mqf_ram
`default_nettype wire

@@ src/mqf_update.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mqf_update
// Descriptor update: from one queue's head, tail and fill and the requested
// operation, works out the new descriptor, the store access and the status.
// ---------------------------------------------------------------------------
module mqf_update #(
   parameter int QUEUE_DEPTH = 256,
   parameter int PW          = $clog2(QUEUE_DEPTH),
   parameter int FW          = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic [mqf_pkg::KIND_W-1:0] kind,
   input  wire logic                       in_range,
   input  wire logic [PW-1:0]              head,
   input  wire logic [PW-1:0]              tail,
   input  wire logic [FW-1:0]              fill,
   output logic      [PW-1:0]              head_in,
   output logic      [PW-1:0]              tail_in,
   output logic      [FW-1:0]              fill_in,
   output mqf_pkg::upd_ctrl_type           ctrl
);
   import mqf_pkg::*;

   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

   logic          is_full;
   logic          is_empty;
   logic [PW-1:0] head_next;
   logic [PW-1:0] tail_next;

   assign is_full   = (fill >= FULL_FILL);
   assign is_empty  = (fill == '0);
   assign head_next = (head == LAST_SLOT) ? '0 : PW'(head + 1'b1);
   assign tail_next = (tail == LAST_SLOT) ? '0 : PW'(tail + 1'b1);

   always_comb begin
      head_in      = head;
      tail_in      = tail;
      fill_in      = fill;
      ctrl.desc_we = 1'b0;
      ctrl.elem_we = 1'b0;
      ctrl.elem_re = 1'b0;
      ctrl.status  = STAT_OK;
      if (!in_range) begin
         // queue index beyond the configured count: no effect
         fill_in = '0;
      end else begin
         unique case (op_type'(kind))
            OP_PUSH: begin
               if (is_full) begin
                  ctrl.status = STAT_FULL;
               end else begin
                  tail_in      = tail_next;
                  fill_in      = FW'(fill + 1'b1);
                  ctrl.desc_we = 1'b1;
                  ctrl.elem_we = 1'b1;
               end
            end
            OP_POP: begin
               if (is_empty) begin
                  ctrl.status = STAT_EMPTY;
               end else begin
                  head_in      = head_next;
                  fill_in      = FW'(fill - 1'b1);
                  ctrl.desc_we = 1'b1;
                  ctrl.elem_re = 1'b1;
               end
            end
            OP_CLEAR: begin
               head_in      = '0;
               tail_in      = '0;
               fill_in      = '0;
               ctrl.desc_we = 1'b1;
            end
            OP_QUERY: begin
               ctrl.desc_we = 1'b0;
            end
            default: begin
               ctrl.desc_we = 1'b0;
            end
         endcase
      end
   end

endmodule : mqf_update
`default_nettype wire

@@ src/multi_queue_fifo_engine.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// multi_queue_fifo_engine
// Several independent circular fifo queues sharing one element RAM, with a
// per-queue descriptor (head, tail, fill) kept in a small descriptor RAM.
// ---------------------------------------------------------------------------
// Each request names a queue and pushes a word, pops the oldest word, clears
// the queue or queries it; each request gives exactly one response with the
// popped word (zero unless a pop succeeded), a status (ok, pop from empty,
// push to full dropped) and the queue's empty flag and fill count after the
// request. A push to a full queue and a pop from an empty queue leave the
// queue unchanged. A request for a queue index at or above QUEUE_COUNT has no
// effect and answers ok, empty, fill zero. One request is worked on at a
// time: the descriptor RAM read at the accepting edge, then the descriptor
// write-back together with the element RAM access, then the response
// register load, which waits in S_FINISH until the response slot is free.
// The next request is accepted in the cycle after the response is loaded,
// even while that response still waits for rsp_ready, so a new request is
// not taken before the last one has been loaded as a response.
// Descriptors have a valid bit per queue that reset clears, so no clearing
// pass is needed and the block is ready right after reset. Element RAM
// contents are never reset; only words that were pushed are ever read.
// ---------------------------------------------------------------------------
module multi_queue_fifo_engine #(
   parameter int QUEUE_COUNT = mqf_pkg::MQF_QUEUE_COUNT,
   parameter int QUEUE_DEPTH = mqf_pkg::MQF_QUEUE_DEPTH,
   parameter int DATA_WIDTH  = mqf_pkg::MQF_DATA_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [mqf_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [mqf_pkg::QSEL_W-1:0]     req_queue_select,
   input  wire logic [mqf_pkg::PUSH_W-1:0]     req_push_data,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [mqf_pkg::POP_W-1:0]      rsp_pop_data,
   output logic      [mqf_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                rsp_queue_empty,
   output logic      [mqf_pkg::FILL_OUT_W-1:0] rsp_queue_fill
);
   import mqf_pkg::*;

   // derived widths
   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = 2 * PW + FW;
   localparam int ENTRIES = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int AW = $clog2(ENTRIES);
   // stored word width: the request field caps what can ever be stored
   localparam int SW = (DATA_WIDTH < PUSH_W) ? DATA_WIDTH : PUSH_W;
   localparam int QCMP_W = QSEL_W + 9;

   // controller state
   state_type state_ff;
   state_type state_in;

   // captured request
   logic [KIND_W-1:0] kind_ff;
   logic [QSEL_W-1:0] qsel_ff;
   logic [SW-1:0]     word_ff;
   logic              in_range_ff;

   // per-queue descriptor valid bits
   logic              desc_valid_ff [QUEUE_COUNT];

   // result of the lookup step
   status_type        res_status_ff;
   logic [FW-1:0]     res_fill_ff;
   logic              pop_ok_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [POP_W-1:0]      rsp_pop_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_queue_empty_ff;
   logic [FILL_OUT_W-1:0] rsp_queue_fill_ff;

   // handshake and step strobes
   logic accept;
   logic lookup;
   logic load_rsp;

   // descriptor ram
   logic [QW-1:0] q_idx;
   logic [DW-1:0] desc_rdata;
   logic [DW-1:0] desc_wdata;
   logic          desc_hit;
   logic [PW-1:0] cur_head;
   logic [PW-1:0] cur_tail;
   logic [FW-1:0] cur_fill;
   logic [PW-1:0] head_in;
   logic [PW-1:0] tail_in;
   logic [FW-1:0] fill_in;
   upd_ctrl_type  ctrl;

   // element ram
   logic [AW-1:0] base_addr;
   logic [AW-1:0] elem_addr;
   logic [SW-1:0] elem_rdata;

   // ---------------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      lookup    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            // descriptor read data is valid, write back and touch the store
            lookup   = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // element read data (if any) is valid, wait for a free response slot
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // request capture
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         qsel_ff     <= req_queue_select;
         word_ff     <= SW'(req_push_data);
         in_range_ff <= (QCMP_W'(req_queue_select) < QCMP_W'(QUEUE_COUNT));
      end
   end

   // ---------------------------------------------------------------------
   // descriptor lookup and update
   // ---------------------------------------------------------------------
   assign q_idx = QW'(qsel_ff);

   // a queue never written since reset reads as all zero
   assign desc_hit = in_range_ff && desc_valid_ff[q_idx];
   assign cur_head = desc_hit ? desc_rdata[DW-1 -: PW]      : '0;
   assign cur_tail = desc_hit ? desc_rdata[FW+PW-1 -: PW]   : '0;
   assign cur_fill = desc_hit ? desc_rdata[FW-1:0]          : '0;
   assign desc_wdata = {head_in, tail_in, fill_in};

   mqf_ram #(
      .WIDTH (DW),
      .DEPTH (QUEUE_COUNT),
      .AW    (QW)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (lookup && ctrl.desc_we),
      .wr_addr (q_idx),
      .wr_data (desc_wdata),
      .rd_en   (accept),
      .rd_addr (QW'(req_queue_select)),
      .rd_data (desc_rdata)
   );

   mqf_update #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PW          (PW),
      .FW          (FW)
   ) u_update (
      .kind     (kind_ff),
      .in_range (in_range_ff),
      .head     (cur_head),
      .tail     (cur_tail),
      .fill     (cur_fill),
      .head_in  (head_in),
      .tail_in  (tail_in),
      .fill_in  (fill_in),
      .ctrl     (ctrl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            desc_valid_ff[i] <= 1'b0;
         end
      end else if (lookup && ctrl.desc_we) begin
         desc_valid_ff[q_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup) begin
         res_status_ff <= ctrl.status;
         res_fill_ff   <= fill_in;
         pop_ok_ff     <= ctrl.elem_re;
      end
   end

   // ---------------------------------------------------------------------
   // element store: push writes at the tail, pop reads at the head
   // ---------------------------------------------------------------------
   assign base_addr = AW'(q_idx * QUEUE_DEPTH);
   assign elem_addr = AW'(base_addr + AW'(ctrl.elem_we ? cur_tail : cur_head));

   mqf_ram #(
      .WIDTH (SW),
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (lookup && ctrl.elem_we),
      .wr_addr (elem_addr),
      .wr_data (word_ff),
      .rd_en   (lookup && ctrl.elem_re),
      .rd_addr (elem_addr),
      .rd_data (elem_rdata)
   );

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pop_data_ff    <= pop_ok_ff ? POP_W'(elem_rdata) : '0;
         rsp_status_ff      <= res_status_ff;
         rsp_queue_empty_ff <= (res_fill_ff == '0);
         rsp_queue_fill_ff  <= FILL_OUT_W'(res_fill_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pop_data    = rsp_pop_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_queue_fill  = rsp_queue_fill_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a lookup always follows an accepted request
   a_lookup_after_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |-> $past(accept))
      else $error("lookup without an accepted request");

   // the element store is never read and written by the same request
   a_elem_one_access : assert property (@(posedge clock) disable iff (reset)
      lookup |-> !(ctrl.elem_we && ctrl.elem_re))
      else $error("element store read and written together");

   // a failed pop reports an empty queue with no data
   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |->
         (rsp_queue_empty && rsp_pop_data == '0))
      else $error("pop-from-empty response inconsistent");

   // a dropped push reports a queue that is not empty
   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> !rsp_queue_empty)
      else $error("push-to-full response shows an empty queue");

   // a response is only loaded when the slot is free or being drained
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

endmodule : multi_queue_fifo_engine
`default_nettype wire

@@ sim/multi_queue_fifo_engine_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_queue_fifo_engine_tb
// Self-checking bench for the multi-queue fifo engine. A shadow copy of every
// queue (store, head, tail, fill) predicts each response. Responses are
// compared field by field in order. Stimulus covers directed corner cases,
// a fill-to-full and drain pass with pointer wrap, and a random mix, with
// random idling on both channels.
// ---------------------------------------------------------------------------
module multi_queue_fifo_engine_tb;
   import mqf_pkg::*;

   localparam int QUEUES       = MQF_QUEUE_COUNT;
   localparam int DEPTH        = MQF_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 100;
   localparam int TAIL_CYCLES  = 8;
   localparam int MIX_REQUESTS = 160;

   // fields of one response
   typedef struct {
      logic [POP_W-1:0]      pop_data;
      status_type            status;
      logic                  empty;
      logic [FILL_OUT_W-1:0] fill;
   } rsp_fields;

   // shadow of all queues plus the responses still owed by the block
   class queue_mirror;
      bit [PUSH_W-1:0] store [QUEUES*DEPTH];
      int unsigned     head_ptr [QUEUES];
      int unsigned     tail_ptr [QUEUES];
      int unsigned     level [QUEUES];
      rsp_fields       owed [$];
      int              errors;
      int              requests;
      int              responses;
      int              full_drops;
      int              empty_pops;
      int              clears;
      int              wraps;

      function int unsigned advance(int unsigned p);
         if (p == DEPTH - 1) begin
            wraps++;
            return 0;
         end
         return p + 1;
      endfunction

      // accepted request: update the shadow and queue the owed response
      function void note_request(op_type k, logic [QSEL_W-1:0] q, logic [PUSH_W-1:0] data);
         rsp_fields e;
         e = '{pop_data: '0, status: STAT_OK, empty: 1'b1, fill: '0};
         requests++;
         if (q < QUEUES) begin
            case (k)
               OP_PUSH: begin
                  if (level[q] >= DEPTH) begin
                     e.status = STAT_FULL;
                     full_drops++;
                  end else begin
                     store[q*DEPTH + tail_ptr[q]] = data;
                     tail_ptr[q] = advance(tail_ptr[q]);
                     level[q]++;
                  end
               end
               OP_POP: begin
                  if (level[q] == 0) begin
                     e.status = STAT_EMPTY;
                     empty_pops++;
                  end else begin
                     e.pop_data = store[q*DEPTH + head_ptr[q]];
                     head_ptr[q] = advance(head_ptr[q]);
                     level[q]--;
                  end
               end
               OP_CLEAR: begin
                  head_ptr[q] = 0;
                  tail_ptr[q] = 0;
                  level[q] = 0;
                  clears++;
               end
               default: ;
            endcase
            e.fill  = FILL_OUT_W'(level[q]);
            e.empty = (level[q] == 0);
         end
         owed.push_back(e);
      endfunction

      function void check_response(logic [POP_W-1:0] pop_data, logic [STATUS_W-1:0] status,
                                   logic empty, logic [FILL_OUT_W-1:0] fill);
         rsp_fields e;
         responses++;
         if (owed.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = owed.pop_front();
         if (pop_data !== e.pop_data) begin
            $error("pop_data: expected %h, actual %h", e.pop_data, pop_data);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (empty !== e.empty) begin
            $error("queue_empty: expected %0d, actual %0d", e.empty, empty);
            errors++;
         end
         if (fill !== e.fill) begin
            $error("queue_fill: expected %0d, actual %0d", e.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind;
   logic [QSEL_W-1:0]     req_queue_select;
   logic [PUSH_W-1:0]     req_push_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [POP_W-1:0]      rsp_pop_data;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_queue_empty;
   logic [FILL_OUT_W-1:0] rsp_queue_fill;

   queue_mirror mirror = new();
   int          cycles;
   bit          sender_eager;
   bit          receiver_eager;

   multi_queue_fifo_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_queue_select (req_queue_select),
      .req_push_data    (req_push_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pop_data     (rsp_pop_data),
      .rsp_status       (rsp_status),
      .rsp_queue_empty  (rsp_queue_empty),
      .rsp_queue_fill   (rsp_queue_fill)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog: a lost or stuck response ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_queue_fifo_engine test failed");
         $finish;
      end
   end

   // idle cycles before the next handshake; eager stretches use none
   function automatic int draw_gap(inout bit eager);
      if ($urandom_range(0, 29) == 0)
         eager = !eager;
      return eager ? 0 : int'($urandom_range(0, 11));
   endfunction

   // mostly pushes and pops, some clears and queries
   function automatic op_type pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return OP_PUSH;
      if (r < 85) return OP_POP;
      if (r < 92) return OP_CLEAR;
      return OP_QUERY;
   endfunction

   // offer one request, called and returning at a falling edge
   task automatic send_request(op_type k, logic [QSEL_W-1:0] q, logic [PUSH_W-1:0] data);
      int gap;
      gap = draw_gap(sender_eager);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_queue_select <= q;
      req_push_data    <= data;
      // accepted when ready is seen high at a rising edge
      do @(posedge clock); while (req_ready !== 1'b1);
      mirror.note_request(k, q, data);
      @(negedge clock);
   endtask

   // hold the request side until every owed response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (mirror.owed.size() != 0) @(negedge clock);
   endtask

   // response side: random ready gaps, one long hold-off to back up the block
   initial begin
      bit held_off;
      int gap;
      int held;
      rsp_ready = 1'b0;
      held_off = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && mirror.responses >= HOLD_AT) begin
            // long stall while the sender keeps offering requests
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            held_off = 1'b1;
         end
         gap = draw_gap(receiver_eager);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         mirror.check_response(rsp_pop_data, rsp_status, rsp_queue_empty, rsp_queue_fill);
         @(negedge clock);
      end
   end

   // main sequence
   initial begin
      int unsigned qf;
      int unsigned q;
      int unsigned last_q;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = OP_QUERY;
      req_queue_select = '0;
      req_push_data    = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: data extremes, every operation, empty pop, clear
      send_request(OP_QUERY, 3'd0, 32'h0);
      send_request(OP_POP,   3'd7, 32'hffff_ffff);
      send_request(OP_PUSH,  3'd0, 32'h0000_0000);
      send_request(OP_PUSH,  3'd0, 32'hffff_ffff);
      send_request(OP_PUSH,  3'd7, 32'ha5a5_a5a5);
      send_request(OP_PUSH,  3'd3, 32'h5a5a_5a5a);
      send_request(OP_QUERY, 3'd0, 32'h0);
      send_request(OP_POP,   3'd0, 32'h0);
      send_request(OP_POP,   3'd0, 32'h0);
      send_request(OP_POP,   3'd0, 32'h0);
      send_request(OP_POP,   3'd7, 32'h0);
      send_request(OP_PUSH,  3'd3, 32'h8000_0000);
      send_request(OP_PUSH,  3'd3, 32'h0000_0001);
      send_request(OP_CLEAR, 3'd3, 32'h0);
      send_request(OP_QUERY, 3'd3, 32'h0);
      send_request(OP_POP,   3'd3, 32'h0);
      // the first push after the clear restarts at slot zero
      send_request(OP_PUSH,  3'd3, 32'h1234_5678);
      send_request(OP_POP,   3'd3, 32'h0);
      send_request(OP_PUSH,  3'd5, 32'h7fff_ffff);
      send_request(OP_CLEAR, 3'd6, 32'h0);
      send_request(OP_QUERY, 3'd4, 32'h0);
      wait_drained();

      // fill one queue to full so tail wraps, overflow it, churn pops and pushes,
      // then drain past empty so head wraps; other queues get noise
      qf = $urandom_range(0, QUEUES - 1);
      send_request(OP_CLEAR, QSEL_W'(qf), $urandom);
      for (int i = 0; i < DEPTH + 3; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_request(pick_kind(), QSEL_W'((qf + $urandom_range(1, 7)) % 8), $urandom);
         send_request(OP_PUSH, QSEL_W'(qf), $urandom);
      end
      send_request(OP_QUERY, QSEL_W'(qf), $urandom);
      for (int i = 0; i < 60; i++) begin
         send_request(OP_POP,  QSEL_W'(qf), $urandom);
         send_request(OP_PUSH, QSEL_W'(qf), $urandom);
      end
      for (int i = 0; i < DEPTH + 1; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_request(pick_kind(), QSEL_W'((qf + $urandom_range(1, 7)) % 8), $urandom);
         send_request(OP_POP, QSEL_W'(qf), $urandom);
      end
      wait_drained();

      // random mix, often hitting the same queue back to back
      last_q = 0;
      for (int i = 0; i < MIX_REQUESTS; i++) begin
         q = ($urandom_range(0, 1) == 0) ? last_q : $urandom_range(0, QUEUES - 1);
         send_request(pick_kind(), QSEL_W'(q), $urandom);
         last_q = q;
      end

      // all requests in: wait for the owed responses, then wait TAIL_CYCLES more
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("ran %0d requests and checked %0d responses over %0d cycles",
               mirror.requests, mirror.responses, cycles);
      $display("saw %0d full drops, %0d empty pops, %0d clears, %0d pointer wraps",
               mirror.full_drops, mirror.empty_pops, mirror.clears, mirror.wraps);
      if (mirror.errors == 0 && mirror.owed.size() == 0) begin
         $display("multi_queue_fifo_engine test passed");
      end else begin
         $display("multi_queue_fifo_engine test failed");
      end
      $finish;
   end

endmodule
